// ===== hw/rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Field widths, register indexes and gesture event codes.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Payload widths
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int EVENT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE           = 3'd0,
        CFG_PRESSED_LOW      = 3'd1,
        CFG_PRESS_DEBOUNCE   = 3'd2,
        CFG_RELEASE_DEBOUNCE = 3'd3,
        CFG_LONG_LIMIT       = 3'd4,
        CFG_VERY_LONG_LIMIT  = 3'd5,
        CFG_DOUBLE_WINDOW    = 3'd6,
        CFG_HOLD_TIMEOUT     = 3'd7
    } cfg_idx_t;

    // Gesture event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_CLICK     = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_LONG      = 3'd3,
        EV_VERY_LONG = 3'd4,
        EV_TIMEOUT   = 3'd5,
        EV_ERROR     = 3'd6
    } event_t;

endpackage

// ===== hw/rtl/bcc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_in_if: pin sample channel
// One beat carries a raw pin level, a millisecond timestamp and a take flag.
// ----------------------------------------------------------------------------
interface bcc_in_if
    import bcc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              pin_level;
    logic [TIME_W-1:0] now_ms;
    logic              take_event;

    modport source (output valid, output pin_level, output now_ms, output take_event,
                    input ready);
    modport sink   (input valid, input pin_level, input now_ms, input take_event,
                    output ready);
endinterface

// ===== hw/rtl/bcc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_out_if: classification result channel
// One beat carries the latched gesture event and the current pressed level.
// ----------------------------------------------------------------------------
interface bcc_out_if
    import bcc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic               pressed_now;

    modport source (output valid, output event_res, output pressed_now, input ready);
    modport sink   (input valid, input event_res, input pressed_now, output ready);
endinterface

// ===== hw/rtl/button_click_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_top: debounce and gesture classifier
//
//   port      dir    beat contents
//   --------  -----  ---------------------------------------------
//   in_ch     sink   pin_level, now_ms[31:0], take_event
//   out_ch    source event_res[2:0], pressed_now
//   cfg_*     in     cfg_we, cfg_index[2:0], cfg_wdata[15:0]
//
// One beat in, one beat out; a beat is taken every cycle when the output
// side keeps up. A beat passes an input register, then the phase update
// and the output register. The phase machine state advances as the beat
// moves into the output register. Reset is asynchronous, active low, and
// restores the register defaults. A stalled output holds its beat and
// the input register backs up behind it.
// ----------------------------------------------------------------------------
module button_click_classifier_top
    import bcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bcc_in_if.sink                in_ch,
    bcc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        PH_WAIT_PRESS   = 3'd0,
        PH_DEB_PRESS    = 3'd1,
        PH_WAIT_RELEASE = 3'd2,
        PH_DEB_RELEASE  = 3'd3,
        PH_WAIT_DOUBLE  = 3'd4,
        PH_TIMEOUT_HOLD = 3'd5
    } phase_t;

    // Configuration registers
    logic               enable_reg;
    logic               pressed_low_reg;
    logic [LIMIT_W-1:0] press_debounce_reg;
    logic [LIMIT_W-1:0] release_debounce_reg;
    logic [LIMIT_W-1:0] long_limit_reg;
    logic [LIMIT_W-1:0] very_long_limit_reg;
    logic [LIMIT_W-1:0] double_window_reg;
    logic [LIMIT_W-1:0] hold_timeout_reg;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_take_reg;

    // Classifier state
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] mark_time_reg, mark_time_next;
    logic              second_press_reg, second_press_next;
    event_t            latched_reg, latched_next;

    // Output stage
    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic               out_pressed_reg;

    logic              advance;
    logic              pressed;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_mark;
    logic [LIMIT_W:0]  error_limit;
    event_t            event_upd;

    // Pipeline flow control
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg           <= 1'b0;
            pressed_low_reg      <= 1'b1;
            press_debounce_reg   <= LIMIT_W'(50);
            release_debounce_reg <= LIMIT_W'(50);
            long_limit_reg       <= LIMIT_W'(1000);
            very_long_limit_reg  <= LIMIT_W'(3000);
            double_window_reg    <= LIMIT_W'(300);
            hold_timeout_reg     <= LIMIT_W'(5000);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:           enable_reg           <= cfg_wdata[0];
                CFG_PRESSED_LOW:      pressed_low_reg      <= cfg_wdata[0];
                CFG_PRESS_DEBOUNCE:   press_debounce_reg   <= cfg_wdata;
                CFG_RELEASE_DEBOUNCE: release_debounce_reg <= cfg_wdata;
                CFG_LONG_LIMIT:       long_limit_reg       <= cfg_wdata;
                CFG_VERY_LONG_LIMIT:  very_long_limit_reg  <= cfg_wdata;
                CFG_DOUBLE_WINDOW:    double_window_reg    <= cfg_wdata;
                CFG_HOLD_TIMEOUT:     hold_timeout_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_pin_reg  <= in_ch.pin_level;
            s1_now_reg  <= in_ch.now_ms;
            s1_take_reg <= in_ch.take_event;
        end
    end

    // Timing differences, modulo 2^32
    assign pressed     = pressed_low_reg ? !s1_pin_reg : s1_pin_reg;
    assign held        = s1_now_reg - press_start_reg;
    assign since_mark  = s1_now_reg - mark_time_reg;
    assign error_limit = {hold_timeout_reg, 1'b0};

    // Phase machine next state
    always_comb
    begin
        phase_next        = phase_reg;
        press_start_next  = press_start_reg;
        mark_time_next    = mark_time_reg;
        second_press_next = second_press_reg;
        event_upd         = latched_reg;

        if (enable_reg)
        begin
            case (phase_reg)
                PH_DEB_PRESS:
                begin
                    if (held >= TIME_W'(press_debounce_reg))
                    begin
                        if (pressed)
                        begin
                            phase_next = PH_WAIT_RELEASE;
                        end
                        else
                        begin
                            phase_next        = PH_WAIT_PRESS;
                            second_press_next = 1'b0;
                        end
                    end
                end
                PH_WAIT_RELEASE:
                begin
                    if (!pressed)
                    begin
                        if (held >= TIME_W'(very_long_limit_reg))
                        begin
                            phase_next        = PH_WAIT_PRESS;
                            second_press_next = 1'b0;
                            event_upd         = EV_VERY_LONG;
                        end
                        else if (held >= TIME_W'(long_limit_reg))
                        begin
                            phase_next        = PH_WAIT_PRESS;
                            second_press_next = 1'b0;
                            event_upd         = EV_LONG;
                        end
                        else
                        begin
                            mark_time_next = s1_now_reg;
                            phase_next     = PH_DEB_RELEASE;
                        end
                    end
                    else if (held >= TIME_W'(hold_timeout_reg))
                    begin
                        mark_time_next = s1_now_reg;
                        phase_next     = PH_TIMEOUT_HOLD;
                    end
                end
                PH_DEB_RELEASE:
                begin
                    if (since_mark >= TIME_W'(release_debounce_reg))
                    begin
                        phase_next = PH_WAIT_DOUBLE;
                    end
                end
                PH_WAIT_DOUBLE:
                begin
                    // second press restarts press timing
                    if (pressed && !second_press_reg)
                    begin
                        press_start_next  = s1_now_reg;
                        second_press_next = 1'b1;
                        phase_next        = PH_DEB_PRESS;
                    end
                    else if (since_mark >= TIME_W'(double_window_reg))
                    begin
                        event_upd         = second_press_reg ? EV_DOUBLE : EV_CLICK;
                        phase_next        = PH_WAIT_PRESS;
                        second_press_next = 1'b0;
                    end
                end
                PH_TIMEOUT_HOLD:
                begin
                    if (!pressed)
                    begin
                        if (since_mark >= TIME_W'(release_debounce_reg))
                        begin
                            mark_time_next    = s1_now_reg;
                            phase_next        = PH_WAIT_PRESS;
                            second_press_next = 1'b0;
                            event_upd         = EV_TIMEOUT;
                        end
                    end
                    else
                    begin
                        mark_time_next = s1_now_reg;
                        if (held >= TIME_W'(error_limit))
                        begin
                            phase_next        = PH_WAIT_PRESS;
                            second_press_next = 1'b0;
                            event_upd         = EV_ERROR;
                        end
                    end
                end
                default:
                begin
                    // wait for press; unused codes fall back here
                    if (phase_reg != PH_WAIT_PRESS)
                    begin
                        phase_next        = PH_WAIT_PRESS;
                        second_press_next = 1'b0;
                    end
                    if (pressed)
                    begin
                        press_start_next = s1_now_reg;
                        phase_next       = PH_DEB_PRESS;
                    end
                end
            endcase
        end

        // take clears after this beat's report
        latched_next = s1_take_reg ? EV_NONE : event_upd;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT_PRESS;
            press_start_reg  <= '0;
            mark_time_reg    <= '0;
            second_press_reg <= 1'b0;
            latched_reg      <= EV_NONE;
            out_valid_reg    <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                phase_reg        <= phase_next;
                press_start_reg  <= press_start_next;
                mark_time_reg    <= mark_time_next;
                second_press_reg <= second_press_next;
                latched_reg      <= latched_next;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_event_reg   <= event_upd;
            out_pressed_reg <= enable_reg && pressed;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.event_res   = out_event_reg;
    assign out_ch.pressed_now = out_pressed_reg;

endmodule
